// ===== rtl/sdw_pkg.sv =====
// Package for the SD data block writer: payload structs, queue entry type,
// phase codes and the CRC16 bit step. No dependencies.
`default_nettype none

package sdw_pkg;

    localparam int LANES      = 4;
    localparam int CRC_W      = 16;
    localparam int CRC_CYCLES = 16;
    localparam int ADDR_W     = 3;
    localparam int DATA_W     = 32;
    localparam int QDEPTH     = 2;
    localparam int QPTR_W     = 1;
    localparam int QCNT_W     = 2;
    localparam int CNT_W      = 4;

    localparam logic [CRC_W-1:0] CRC_POLY  = 16'h1021;
    localparam logic [LANES-1:0] ALL_LINES = 4'hf;

    localparam logic [1:0] PH_START = 2'd0;
    localparam logic [1:0] PH_DATA  = 2'd1;
    localparam logic [1:0] PH_CRC   = 2'd2;
    localparam logic [1:0] PH_STOP  = 2'd3;

    localparam logic [ADDR_W-1:0] REG_BUS_WIDTH = 3'd0;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_in_item;

    typedef struct packed {
        logic [LANES-1:0] dat_lines;
        logic [1:0]       phase;
        logic             last_cycle;
    } t_out_item;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
        logic       four_bit;
        logic       start;
    } t_job;

    function automatic logic [CRC_W-1:0] crc_bit(input logic [CRC_W-1:0] crc,
                                                 input logic bit_in);
        logic [CRC_W-1:0] nxt;
        nxt = {crc[CRC_W-2:0], 1'b0};
        if (crc[CRC_W-1] ^ bit_in) begin
            nxt = nxt ^ CRC_POLY;
        end
        return nxt;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/sdw_front.sv =====
// Front end: configuration register, input acceptance and block-start tagging.
// Depends on sdw_pkg.
`default_nettype none

module sdw_front (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      psel,
    input  wire logic                      penable,
    input  wire logic                      pwrite,
    input  wire logic [sdw_pkg::ADDR_W-1:0] paddr,
    input  wire logic [sdw_pkg::DATA_W-1:0] pwdata,
    output logic      [sdw_pkg::DATA_W-1:0] prdata,
    output logic                           pready,
    input  wire logic                      i_in_valid,
    input  wire sdw_pkg::t_in_item         i_in_data,
    input  wire logic                      i_q_full,
    output logic                           o_push,
    output sdw_pkg::t_job                  o_job
);

    logic r_four;
    logic r_open;
    logic wr_reg;
    logic accept;

    assign pready = 1'b1;
    assign wr_reg = psel && penable && pwrite && (paddr[sdw_pkg::ADDR_W-1] == 1'b0);

    always_comb begin
        prdata = '0;
        if (paddr[sdw_pkg::ADDR_W-1] == 1'b0) begin
            prdata[0] = r_four;
        end
    end

    assign accept = i_in_valid && !i_q_full;
    assign o_push = i_in_valid;

    always_comb begin
        o_job.data_byte = i_in_data.data_byte;
        o_job.last_byte = i_in_data.last_byte;
        o_job.four_bit  = r_four;
        o_job.start     = !r_open;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_four <= 1'b1;
            r_open <= 1'b0;
        end else begin
            if (wr_reg) begin
                r_four <= pwdata[0];
            end
            if (accept) begin
                r_open <= !i_in_data.last_byte;
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/sdw_queue.sv =====
// Two-entry job queue between the front end and the bit sequencer.
// Depends on sdw_pkg.
`default_nettype none

module sdw_queue (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire sdw_pkg::t_job i_job,
    output logic               o_full,
    input  wire logic          i_pop,
    output logic               o_head_valid,
    output sdw_pkg::t_job      o_head
);

    sdw_pkg::t_job                 r_mem [sdw_pkg::QDEPTH];
    logic [sdw_pkg::QPTR_W-1:0]    r_wptr;
    logic [sdw_pkg::QPTR_W-1:0]    r_rptr;
    logic [sdw_pkg::QCNT_W-1:0]    r_count;
    logic                          do_push;
    logic                          do_pop;

    assign o_full       = (r_count == sdw_pkg::QCNT_W'(sdw_pkg::QDEPTH));
    assign o_head_valid = (r_count != '0);
    assign o_head       = r_mem[r_rptr];
    assign do_push      = i_push && !o_full;
    assign do_pop       = i_pop && o_head_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (do_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== rtl/sdw_back.sv =====
// Bit sequencer: start, data, CRC and stop cycles, per-lane CRC16, output register.
// Depends on sdw_pkg.
`default_nettype none

module sdw_back (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_head_valid,
    input  wire sdw_pkg::t_job      i_head,
    output logic                    o_pop,
    output logic                    o_out_valid,
    output sdw_pkg::t_out_item      o_out_data,
    input  wire logic               i_out_stall
);

    typedef enum logic [2:0] {S_IDLE, S_START, S_DATA, S_CRC, S_STOP} t_state;

    t_state                                      r_state, n_state;
    sdw_pkg::t_job                               r_job, n_job;
    logic [sdw_pkg::CNT_W-1:0]                   r_cnt, n_cnt;
    logic [sdw_pkg::LANES-1:0][sdw_pkg::CRC_W-1:0] r_crc, n_crc;
    logic                                        r_oval, n_oval;
    sdw_pkg::t_out_item                          r_out, n_out;
    logic                                        adv;
    logic [sdw_pkg::LANES-1:0]                   data_lines;
    logic [sdw_pkg::LANES-1:0]                   crc_lines;
    logic [2:0]                                  bit_idx;
    logic                                        data_fin;

    assign adv         = !r_oval || !i_out_stall;
    assign o_out_valid = r_oval;
    assign o_out_data  = r_out;
    assign bit_idx     = ~r_cnt[2:0];

    always_comb begin
        if (r_job.four_bit) begin
            data_lines = r_cnt[0] ? r_job.data_byte[3:0] : r_job.data_byte[7:4];
            data_fin   = (r_cnt == sdw_pkg::CNT_W'(1));
        end else begin
            data_lines = {sdw_pkg::LANES{r_job.data_byte[bit_idx]}};
            data_fin   = (r_cnt == sdw_pkg::CNT_W'(7));
        end
        for (int k = 0; k < sdw_pkg::LANES; k++) begin
            crc_lines[k] = r_crc[k][sdw_pkg::CRC_W-1];
        end
    end

    always_comb begin
        n_state = r_state;
        n_job   = r_job;
        n_cnt   = r_cnt;
        n_crc   = r_crc;
        n_oval  = r_oval;
        n_out   = r_out;
        o_pop   = 1'b0;
        if (adv) begin
            n_oval = 1'b0;
            case (r_state)
                S_IDLE: begin
                end
                S_START: begin
                    n_oval  = 1'b1;
                    n_out   = '{dat_lines: '0, phase: sdw_pkg::PH_START, last_cycle: 1'b0};
                    n_crc   = '0;
                    n_state = S_DATA;
                    n_cnt   = '0;
                end
                S_DATA: begin
                    n_oval = 1'b1;
                    n_out  = '{dat_lines: data_lines, phase: sdw_pkg::PH_DATA,
                               last_cycle: data_fin && !r_job.last_byte};
                    for (int k = 0; k < sdw_pkg::LANES; k++) begin
                        n_crc[k] = sdw_pkg::crc_bit(r_crc[k], data_lines[k]);
                    end
                    if (!data_fin) begin
                        n_cnt = r_cnt + 1'b1;
                    end else if (r_job.last_byte) begin
                        n_state = S_CRC;
                        n_cnt   = '0;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
                S_CRC: begin
                    n_oval = 1'b1;
                    n_out  = '{dat_lines: crc_lines, phase: sdw_pkg::PH_CRC, last_cycle: 1'b0};
                    for (int k = 0; k < sdw_pkg::LANES; k++) begin
                        n_crc[k] = {r_crc[k][sdw_pkg::CRC_W-2:0], 1'b0};
                    end
                    if (r_cnt == sdw_pkg::CNT_W'(sdw_pkg::CRC_CYCLES - 1)) begin
                        n_state = S_STOP;
                    end else begin
                        n_cnt = r_cnt + 1'b1;
                    end
                end
                S_STOP: begin
                    n_oval  = 1'b1;
                    n_out   = '{dat_lines: sdw_pkg::ALL_LINES, phase: sdw_pkg::PH_STOP,
                                last_cycle: 1'b1};
                    n_crc   = '0;
                    n_state = S_IDLE;
                end
                default: begin
                    n_state = S_IDLE;
                end
            endcase
            // next job starts as soon as the current one leaves its final cycle
            if (n_state == S_IDLE && i_head_valid) begin
                o_pop   = 1'b1;
                n_job   = i_head;
                n_cnt   = '0;
                n_state = i_head.start ? S_START : S_DATA;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_oval  <= 1'b0;
            r_cnt   <= '0;
            r_crc   <= '0;
        end else begin
            r_state <= n_state;
            r_oval  <= n_oval;
            r_cnt   <= n_cnt;
            r_crc   <= n_crc;
        end
        r_job <= n_job;
        r_out <= n_out;
    end

endmodule

`default_nettype wire

// ===== rtl/sd_data_block_writer_crc16_core.sv =====
// Top level of the SD data block writer with per-line CRC16.
// Instantiates sdw_front, sdw_queue and sdw_back; depends on sdw_pkg.
//
//   channel  | valid       | stall        | payload
//   ---------+-------------+--------------+---------------------------
//   input    | i_in_valid  | o_in_stall   | i_in_data  (t_in_item)
//   output   | o_out_valid | i_out_stall  | o_out_data (t_out_item)
//   config   | APB psel/penable/pwrite, paddr, pwdata, prdata, pready
//
// One output transaction per cycle from the sequencer unless the output stalls;
// bytes go out by nibble (4-bit) or bit (1-bit), with start, CRC and stop as due.
// A two-entry queue lets bytes be taken while the sequencer is busy.
// Synchronous active-low reset; bus width resets to 4-bit, no block open.
// Output stall freezes the sequencer; input stall is high while the queue is full.
`default_nettype none

module sd_data_block_writer_crc16_core (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [sdw_pkg::ADDR_W-1:0] paddr,
    input  wire logic [sdw_pkg::DATA_W-1:0] pwdata,
    output logic      [sdw_pkg::DATA_W-1:0] prdata,
    output logic                            pready,
    input  wire logic                       i_in_valid,
    input  wire sdw_pkg::t_in_item          i_in_data,
    output logic                            o_in_stall,
    output logic                            o_out_valid,
    output sdw_pkg::t_out_item              o_out_data,
    input  wire logic                       i_out_stall
);

    logic          q_full;
    logic          push;
    sdw_pkg::t_job job;
    logic          pop;
    logic          head_valid;
    sdw_pkg::t_job head;

    assign o_in_stall = q_full;

    sdw_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .i_in_valid (i_in_valid),
        .i_in_data  (i_in_data),
        .i_q_full   (q_full),
        .o_push     (push),
        .o_job      (job)
    );

    sdw_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_job        (job),
        .o_full       (q_full),
        .i_pop        (pop),
        .o_head_valid (head_valid),
        .o_head       (head)
    );

    sdw_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head_valid (head_valid),
        .i_head       (head),
        .o_pop        (pop),
        .o_out_valid  (o_out_valid),
        .o_out_data   (o_out_data),
        .i_out_stall  (i_out_stall)
    );

endmodule

`default_nettype wire

// ===== rtl/sdw_checker.sv =====
// Port-level checks for the SD data block writer, bound to the top level.
// Depends on sdw_pkg and sd_data_block_writer_crc16_core.
`default_nettype none

module sdw_checker (
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               pready,
    input wire logic               o_out_valid,
    input wire sdw_pkg::t_out_item o_out_data,
    input wire logic               i_out_stall
);

    a_pready_high: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pready)
        else $error("pready dropped");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("output transaction changed while stalled");

    a_stop_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.phase == sdw_pkg::PH_STOP |->
            o_out_data.dat_lines == sdw_pkg::ALL_LINES && o_out_data.last_cycle)
        else $error("stop cycle malformed");

    a_start_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.phase == sdw_pkg::PH_START |->
            o_out_data.dat_lines == '0 && !o_out_data.last_cycle)
        else $error("start cycle malformed");

    a_crc_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.phase == sdw_pkg::PH_CRC |-> !o_out_data.last_cycle)
        else $error("crc cycle flagged as last");

endmodule

bind sd_data_block_writer_crc16_core sdw_checker u_sdw_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .pready      (pready),
    .o_out_valid (o_out_valid),
    .o_out_data  (o_out_data),
    .i_out_stall (i_out_stall)
);

`default_nettype wire

// ===== test/tb.sv =====
// Testbench for sd_data_block_writer_crc16_core: predicts the DAT line cycles of every
// byte and checks each output transaction in order. Depends on sdw_pkg and the core RTL.
`default_nettype none

module tb;
    import sdw_pkg::*;

    localparam logic [15:0] CCITT_POLY = 16'h1021;
    localparam int          MAX_CYCLES = 26;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                psel = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite = 1'b0;
    logic [ADDR_W-1:0]   paddr = '0;
    logic [DATA_W-1:0]   pwdata = '0;
    logic [DATA_W-1:0]   prdata;
    logic                pready;
    logic                i_in_valid = 1'b0;
    t_in_item            i_in_data = '0;
    logic                o_in_stall;
    logic                o_out_valid;
    t_out_item           o_out_data;
    logic                i_out_stall = 1'b0;

    sd_data_block_writer_crc16_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .i_in_valid  (i_in_valid),
        .i_in_data   (i_in_data),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_out_stall (i_out_stall)
    );

    always #5 i_clk = ~i_clk;

    // predictor state
    logic [15:0] crc_of_line [LANES];
    logic        block_open_q = 1'b0;
    logic        width_four_q = 1'b1;
    t_out_item   pending_bus_cycles [$];

    int mismatches = 0;
    bit quiet_tx = 1'b0;
    bit quiet_rx = 1'b0;
    bit hold_request = 1'b0;
    int hold_len = 0;

    function automatic void advance_line_crcs(input logic [LANES-1:0] lines);
        int  k;
        logic fb;
        for (k = 0; k < LANES; k++) begin
            fb = crc_of_line[k][15] ^ lines[k];
            crc_of_line[k] = {crc_of_line[k][14:0], 1'b0} ^ (fb ? CCITT_POLY : 16'h0000);
        end
    endfunction

    function automatic void predict_bus_cycles(input t_in_item it);
        t_out_item        cyc [MAX_CYCLES];
        int               n;
        int               i;
        int               k;
        logic [LANES-1:0] lines;
        n = 0;
        if (!block_open_q) begin
            for (k = 0; k < LANES; k++) crc_of_line[k] = '0;
            block_open_q = 1'b1;
            cyc[n] = {4'h0, PH_START, 1'b0};
            n++;
        end
        if (width_four_q) begin
            lines = it.data_byte[7:4];
            advance_line_crcs(lines);
            cyc[n] = {lines, PH_DATA, 1'b0};
            n++;
            lines = it.data_byte[3:0];
            advance_line_crcs(lines);
            cyc[n] = {lines, PH_DATA, 1'b0};
            n++;
        end else begin
            for (i = 7; i >= 0; i--) begin
                lines = {LANES{it.data_byte[i]}};
                advance_line_crcs(lines);
                cyc[n] = {lines, PH_DATA, 1'b0};
                n++;
            end
        end
        if (it.last_byte) begin
            for (i = 0; i < CRC_CYCLES; i++) begin
                for (k = 0; k < LANES; k++) begin
                    lines[k] = crc_of_line[k][15];
                    crc_of_line[k] = {crc_of_line[k][14:0], 1'b0};
                end
                cyc[n] = {lines, PH_CRC, 1'b0};
                n++;
            end
            cyc[n] = {ALL_LINES, PH_STOP, 1'b0};
            n++;
            for (k = 0; k < LANES; k++) crc_of_line[k] = '0;
            block_open_q = 1'b0;
        end
        cyc[n-1].last_cycle = 1'b1;
        for (i = 0; i < n; i++) pending_bus_cycles.push_back(cyc[i]);
    endfunction

    // one byte transaction; valid stays up on return so a zero-gap byte can follow
    task automatic send_byte(input logic [7:0] data_v, input logic last_v);
        t_in_item it;
        int       gap;
        it.data_byte = data_v;
        it.last_byte = last_v;
        gap = quiet_tx ? 0 : $urandom_range(0, 19);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= it;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        predict_bus_cycles(it);
    endtask

    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (pending_bus_cycles.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic set_bus_width(input logic four);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= REG_BUS_WIDTH;
        pwdata  <= {{(DATA_W-1){1'b0}}, four};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        width_four_q = four;
    endtask

    task automatic test_four_bit_blocks();
        send_byte(8'h00, 1'b1);
        send_byte(8'hff, 1'b1);
        send_byte(8'ha5, 1'b0);
        send_byte(8'h5a, 1'b0);
        send_byte(8'h0f, 1'b0);
        send_byte(8'hf0, 1'b1);
        wait_idle();
    endtask

    task automatic test_one_bit_blocks();
        set_bus_width(1'b0);
        send_byte(8'h80, 1'b1);
        send_byte(8'h01, 1'b1);
        send_byte(8'h7e, 1'b0);
        send_byte(8'hff, 1'b0);
        send_byte(8'h00, 1'b1);
        wait_idle();
    endtask

    // bus width switched while a block is open
    task automatic test_width_switch_in_block();
        set_bus_width(1'b1);
        send_byte(8'h3c, 1'b0);
        wait_idle();
        set_bus_width(1'b0);
        send_byte(8'hc3, 1'b0);
        wait_idle();
        set_bus_width(1'b1);
        send_byte(8'h99, 1'b1);
        send_byte(8'h12, 1'b0);
        wait_idle();
        set_bus_width(1'b0);
        send_byte(8'h34, 1'b1);
        wait_idle();
    endtask

    // receiver holds off long enough for the input side to stall
    task automatic test_backpressure();
        int j;
        set_bus_width(1'b1);
        quiet_tx     = 1'b1;
        hold_len     = 400;
        hold_request = 1'b1;
        for (j = 0; j < 24; j++) send_byte(8'($urandom_range(0, 255)), (j % 8) == 7);
        quiet_tx = 1'b0;
        wait_idle();
    endtask

    task automatic test_random_blocks(input int n_items);
        int sent;
        int len;
        int j;
        sent = 0;
        while (sent < n_items) begin
            if ($urandom_range(0, 3) == 0) begin
                wait_idle();
                set_bus_width(1'($urandom_range(0, 1)));
            end
            quiet_tx = ($urandom_range(0, 5) == 0);
            quiet_rx = ($urandom_range(0, 5) == 0);
            len = ($urandom_range(0, 4) == 0) ? 1 : $urandom_range(2, 12);
            for (j = 0; j < len; j++) begin
                if (j > 0 && $urandom_range(0, 19) == 0) begin
                    wait_idle();
                    set_bus_width(1'($urandom_range(0, 1)));
                end
                send_byte(8'($urandom_range(0, 255)), j == len - 1);
                sent++;
            end
        end
        quiet_tx = 1'b0;
        quiet_rx = 1'b0;
        wait_idle();
    endtask

    // receiver stall pattern
    initial begin
        int gap;
        wait (i_rst_n);
        forever begin
            if (hold_request) begin
                hold_request = 1'b0;
                i_out_stall <= 1'b1;
                repeat (hold_len) @(posedge i_clk);
                gap = 0;
            end else begin
                gap = quiet_rx ? 0 : $urandom_range(0, 19);
            end
            if (gap > 0) begin
                i_out_stall <= 1'b1;
                repeat (gap) @(posedge i_clk);
            end
            i_out_stall <= 1'b0;
            @(posedge i_clk);
            while (!o_out_valid) @(posedge i_clk);
        end
    end

    always @(posedge i_clk) begin : check_bus_cycles
        t_out_item want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_bus_cycles.size() == 0) begin
                $display("%0t: unexpected transaction, expected none actual %h",
                         $time, o_out_data);
                mismatches++;
            end else begin
                want = pending_bus_cycles.pop_front();
                if (o_out_data.dat_lines !== want.dat_lines) begin
                    $display("%0t: dat_lines expected %h actual %h",
                             $time, want.dat_lines, o_out_data.dat_lines);
                    mismatches++;
                end
                if (o_out_data.phase !== want.phase) begin
                    $display("%0t: phase expected %0d actual %0d",
                             $time, want.phase, o_out_data.phase);
                    mismatches++;
                end
                if (o_out_data.last_cycle !== want.last_cycle) begin
                    $display("%0t: last_cycle expected %b actual %b",
                             $time, want.last_cycle, o_out_data.last_cycle);
                    mismatches++;
                end
            end
        end
    end

    initial begin
        for (int k = 0; k < LANES; k++) crc_of_line[k] = '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_four_bit_blocks();
        test_one_bit_blocks();
        test_width_switch_in_block();
        test_backpressure();
        test_random_blocks(340);
        if (mismatches == 0 && pending_bus_cycles.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    initial begin
        #20000000;
        $display("tb: failure");
        $finish;
    end

endmodule

`default_nettype wire
